// ----- rtl/bpe_pkg.sv -----
// ----------------------------------------------------------------------------
// Bezier point evaluator package
// Widths, stream packing offsets and point types shared by the evaluator.
// ----------------------------------------------------------------------------
package bpe_pkg;

  localparam int MAX_POINTS  = 8;
  localparam int IDX_BITS    = $clog2(MAX_POINTS);
  localparam int ORDER_BITS  = 3;
  localparam int COORD_BITS  = 16;
  localparam int T_FRAC_BITS = 16;
  localparam int QFRAC       = 16;
  localparam int WORK_BITS   = COORD_BITS + QFRAC;
  // Difference is one bit wider than a working value, t gets a zero sign bit.
  localparam int MUL_BITS    = (WORK_BITS + 1) + (T_FRAC_BITS + 1);

  // Input tdata layout, lowest bit first.
  localparam int IDX_LSB      = 0;
  localparam int PX_LSB       = IDX_LSB + IDX_BITS;
  localparam int PY_LSB       = PX_LSB + COORD_BITS;
  localparam int TF_LSB       = PY_LSB + COORD_BITS;
  localparam int S_USED_BITS  = TF_LSB + T_FRAC_BITS;
  localparam int S_TDATA_BITS = ((S_USED_BITS + 7) / 8) * 8;
  localparam int M_TDATA_BITS = ((2 * COORD_BITS + 7) / 8) * 8;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_EVAL = 1'b1
  } cmd_t;

  typedef logic signed [COORD_BITS-1:0]  coord_t;
  typedef logic signed [WORK_BITS-1:0]   work_t;
  typedef logic        [IDX_BITS-1:0]    idx_t;
  typedef logic        [ORDER_BITS-1:0]  order_t;
  typedef logic        [T_FRAC_BITS-1:0] tfrac_t;

  typedef struct packed {
    coord_t y;
    coord_t x;
  } ctrl_point_t;

  typedef struct packed {
    work_t y;
    work_t x;
  } work_point_t;

endpackage

// ----- rtl/bezier_point_eval.sv -----
// ----------------------------------------------------------------------------
// Bezier point evaluator
// De Casteljau evaluation of a 2-D Bezier curve on one shared interpolator.
// ----------------------------------------------------------------------------
// A load transfer (tuser = 0) writes one control point. An evaluate
// transfer (tuser = 1) runs the de Casteljau triangle for the current
// order on Q16.16 values and returns the integer part of the curve point
// as one output transfer. All interpolations share one multiplier that
// takes x and y in turn, so each step has an x pass and a y pass; each
// level adds a start and a flush state, and a final start state reads out
// the answer once the output register is free. The input is not ready
// while an evaluate runs. The result sits in an output register, so the
// next transfer can be accepted while it waits to be taken.
module bezier_point_eval (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [bpe_pkg::ORDER_BITS-1:0]  cfg_wdata,     // bezier_order
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // point_index, point_x, point_y, t_frac, zero pad
  input  logic [bpe_pkg::S_TDATA_BITS-1:0] s_axis_tdata,
  input  logic                            s_axis_tuser,  // cmd
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // result_x, result_y
  output logic [bpe_pkg::M_TDATA_BITS-1:0] m_axis_tdata
);
  import bpe_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_MULX,
    ST_MULY,
    ST_FLUSH
  } state_t;

  state_t state;
  order_t bezier_order;
  order_t ord;
  order_t level;
  idx_t   step;
  tfrac_t t_reg;

  ctrl_point_t ctrl_mem [MAX_POINTS];
  work_point_t work_mem [MAX_POINTS];

  work_point_t p;
  work_point_t q_hold;
  work_t       py_old;
  work_t       nx;
  logic signed [MUL_BITS-1:0] prod;

  logic        in_xfer;
  logic        out_free;
  logic        emit;
  order_t      len;
  idx_t        step_inc;
  idx_t        rd_addr;
  ctrl_point_t ctrl_rd;
  work_point_t src;
  logic signed [WORK_BITS:0]     mul_a;
  logic signed [T_FRAC_BITS:0]   mul_b;
  logic signed [MUL_BITS-1:0]    mul_res;
  work_t       add_a;
  work_t       sum;
  logic        wr_en;
  idx_t        wr_addr;

  assign s_axis_tready = (state == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign emit          = (state == ST_START) && (level == ord) && out_free;
  assign len           = ord - level;
  assign step_inc      = step + 1'b1;

  // Level zero interpolates straight from the control points.
  assign rd_addr = (state == ST_MULX) ? step_inc : '0;
  assign ctrl_rd = ctrl_mem[rd_addr];
  always_comb begin
    if (level == '0) begin
      src.x = {ctrl_rd.x, {QFRAC{1'b0}}};
      src.y = {ctrl_rd.y, {QFRAC{1'b0}}};
    end else begin
      src = work_mem[rd_addr];
    end
  end

  always_comb begin
    if (state == ST_MULY) begin
      mul_a = {q_hold.y[WORK_BITS-1], q_hold.y} - {p.y[WORK_BITS-1], p.y};
    end else begin
      mul_a = {src.x[WORK_BITS-1], src.x} - {p.x[WORK_BITS-1], p.x};
    end
  end
  assign mul_b   = signed'({1'b0, t_reg});
  assign mul_res = mul_a * mul_b;

  // The new point lies between p and q, so the sum fits in a working value.
  assign add_a = (state == ST_MULY) ? p.x : py_old;
  assign sum   = add_a + prod[QFRAC +: WORK_BITS];

  // The finished y of the previous step is retired while the next x starts.
  assign wr_en   = (state == ST_FLUSH) || ((state == ST_MULX) && (step != '0));
  assign wr_addr = step - 1'b1;

  always_ff @(posedge clk) begin
    if (in_xfer && (cmd_t'(s_axis_tuser) == CMD_LOAD)) begin
      ctrl_mem[s_axis_tdata[IDX_LSB +: IDX_BITS]] <=
        '{y: s_axis_tdata[PY_LSB +: COORD_BITS], x: s_axis_tdata[PX_LSB +: COORD_BITS]};
    end
    if (wr_en) begin
      work_mem[wr_addr] <= '{y: sum, x: nx};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      bezier_order  <= order_t'(1);
      ord           <= '0;
      level         <= '0;
      step          <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        bezier_order <= cfg_wdata;
      end
      if (m_axis_tvalid && m_axis_tready && !emit) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_xfer && (cmd_t'(s_axis_tuser) == CMD_EVAL)) begin
            t_reg <= s_axis_tdata[TF_LSB +: T_FRAC_BITS];
            ord   <= bezier_order;
            level <= '0;
            state <= ST_START;
          end
        end
        ST_START: begin
          if (level == ord) begin
            if (out_free) begin
              m_axis_tdata  <= {src.y[WORK_BITS-1 -: COORD_BITS],
                                src.x[WORK_BITS-1 -: COORD_BITS]};
              m_axis_tvalid <= 1'b1;
              state         <= ST_IDLE;
            end
          end else begin
            p     <= src;
            step  <= '0;
            state <= ST_MULX;
          end
        end
        ST_MULX: begin
          prod   <= mul_res;
          q_hold <= src;
          state  <= ST_MULY;
        end
        ST_MULY: begin
          prod   <= mul_res;
          nx     <= sum;
          py_old <= p.y;
          p      <= q_hold;
          step   <= step_inc;
          state  <= (step_inc == len) ? ST_FLUSH : ST_MULX;
        end
        ST_FLUSH: begin
          level <= level + 1'b1;
          state <= ST_START;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // A result only appears at the end of the start-of-level readout.
  a_result_from_readout: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state == ST_START) && $past(level == ord))
    else $error("output became valid outside the final readout");

  // The triangle never runs past the configured degree.
  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MULX || state == ST_MULY || state == ST_FLUSH) |-> (level < ord))
    else $error("interpolation level beyond curve order");

  // Every issued step belongs to the current level.
  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MULX) |-> (step < len))
    else $error("interpolation step beyond level length");

endmodule

// ----- sim/bezier_point_eval_test.sv -----
// ----------------------------------------------------------------------------
// Bezier point evaluator testbench
// Loads control points and evaluates curve points over every order from 0 to
// 7. A short table of directed items opens the run, followed by random
// phases. Each phase has its own order. Both stream sides idle at random,
// and once the output side holds off long enough to stall the input.
// Expected results come from a fixed-point de Casteljau predictor or the table.
// ----------------------------------------------------------------------------
module bezier_point_eval_test;
  import bpe_pkg::*;

  localparam int DRAIN_CYCLES = 80;   // longer than the slowest evaluation
  localparam int HOLD_CYCLES  = 400;
  localparam int STALL_LIMIT  = 5000;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 100;
  localparam int NDIR         = 23;

  typedef enum {ROW_LOAD, ROW_EVAL, ROW_ORDER} row_kind_t;

  typedef struct {
    row_kind_t kind;
    idx_t      idx;
    coord_t    x;
    coord_t    y;
    tfrac_t    t;
    order_t    order;
    bit        chk;     // expected point typed in below
    coord_t    ex;
    coord_t    ey;
  } dir_row_t;

  typedef struct {
    coord_t x;
    coord_t y;
  } curve_pt_t;

  logic                    clk;
  logic                    rst = 1'b1;
  logic                    cfg_we = 1'b0;
  logic [ORDER_BITS-1:0]   cfg_wdata = '0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [S_TDATA_BITS-1:0] s_axis_tdata = '0;
  logic                    s_axis_tuser = 1'b0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [M_TDATA_BITS-1:0] m_axis_tdata;

  ctrl_point_t ctrl_pts [MAX_POINTS];
  order_t      curve_order = 1;
  curve_pt_t   curve_q [$];
  bit          idle_on = 1'b1;
  bit          hold_req = 1'b0;
  int          n_loads = 0;
  int          n_evals = 0;
  int          n_results = 0;
  int          n_errors = 0;
  int          quiet = 0;

  // Each evaluation reads only points loaded before it, so no unwritten
  // point is ever read.
  dir_row_t dir_tab [NDIR] = '{
    '{ROW_LOAD,  0, -32768,  32767, 'h0000, 0, 0,      0,     0},
    '{ROW_LOAD,  1,  32767, -32768, 'hFFFF, 0, 0,      0,     0},
    '{ROW_EVAL,  5,   1234,    -99, 'h0000, 0, 1, -32768, 32767},
    '{ROW_EVAL,  0,      0,      0, 'hFFFF, 0, 0,      0,     0},
    '{ROW_EVAL,  7,     -1,     -1, 'h8000, 0, 0,      0,     0},
    '{ROW_LOAD,  2,      0,      0, 'h0000, 0, 0,      0,     0},
    '{ROW_LOAD,  3,     -1,     -1, 'h1234, 0, 0,      0,     0},
    '{ROW_LOAD,  4,  12345, -12345, 'h0000, 0, 0,      0,     0},
    '{ROW_LOAD,  5,  32767,  32767, 'h0000, 0, 0,      0,     0},
    '{ROW_LOAD,  6, -32768, -32768, 'h0000, 0, 0,      0,     0},
    '{ROW_LOAD,  7,      1,     -1, 'h0000, 0, 0,      0,     0},
    '{ROW_ORDER, 0,      0,      0, 'h0000, 0, 0,      0,     0},
    '{ROW_EVAL,  3,    555,   -555, 'h1234, 0, 1, -32768, 32767},
    '{ROW_EVAL,  0,      0,      0, 'hFFFF, 0, 1, -32768, 32767},
    '{ROW_ORDER, 0,      0,      0, 'h0000, 7, 0,      0,     0},
    '{ROW_EVAL,  0,      0,      0, 'h0000, 0, 1, -32768, 32767},
    '{ROW_EVAL,  0,      0,      0, 'hFFFF, 0, 0,      0,     0},
    '{ROW_EVAL,  0,      0,      0, 'h0001, 0, 0,      0,     0},
    '{ROW_LOAD,  0,      5,     -7, 'hFFFF, 0, 0,      0,     0},
    '{ROW_EVAL,  2,  -9999,   9999, 'h0000, 0, 1,      5,    -7},
    '{ROW_ORDER, 0,      0,      0, 'h0000, 3, 0,      0,     0},
    '{ROW_EVAL,  0,      0,      0, 'hAAAA, 0, 0,      0,     0},
    '{ROW_EVAL,  0,      0,      0, 'h5555, 0, 0,      0,     0}
  };

  bezier_point_eval dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // One interpolation step, p + floor((q - p) * t), exact in 64 bits.
  function automatic longint lerp_fix(input longint p, input longint q, input longint t);
    return p + (((q - p) * t) >>> T_FRAC_BITS);
  endfunction

  function automatic void predict_point(input tfrac_t t, output coord_t rx,
                                        output coord_t ry);
    longint wx [MAX_POINTS];
    longint wy [MAX_POINTS];
    longint tt;
    longint fx;
    longint fy;
    int     ord;
    tt  = longint'(t);
    ord = (curve_order > MAX_POINTS - 1) ? MAX_POINTS - 1 : curve_order;
    for (int i = 0; i <= ord; i++) begin
      wx[i] = longint'(ctrl_pts[i].x) <<< QFRAC;
      wy[i] = longint'(ctrl_pts[i].y) <<< QFRAC;
    end
    for (int lvl = 0; lvl < ord; lvl++) begin
      for (int j = 0; j < ord - lvl; j++) begin
        wx[j] = lerp_fix(wx[j], wx[j+1], tt);
        wy[j] = lerp_fix(wy[j], wy[j+1], tt);
      end
    end
    fx = wx[0] >>> QFRAC;
    fy = wy[0] >>> QFRAC;
    rx = fx[COORD_BITS-1:0];
    ry = fy[COORD_BITS-1:0];
  endfunction

  // Extreme values of a 16-bit field half of the time, random otherwise.
  function automatic logic [15:0] rand_edge16();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_item(input cmd_t cmd, input idx_t idx, input coord_t x,
                           input coord_t y, input tfrac_t t, input bit chk,
                           input coord_t ex, input coord_t ey);
    logic [S_TDATA_BITS-1:0] word;
    curve_pt_t               pt;
    int                      gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    word = '0;
    word[IDX_LSB +: IDX_BITS]   = idx;
    word[PX_LSB +: COORD_BITS]  = x;
    word[PY_LSB +: COORD_BITS]  = y;
    word[TF_LSB +: T_FRAC_BITS] = t;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= word;
    do @(posedge clk); while (!s_axis_tready);
    if (cmd == CMD_LOAD) begin
      ctrl_pts[idx].x = x;
      ctrl_pts[idx].y = y;
      n_loads++;
    end else begin
      if (chk) begin
        pt.x = ex;
        pt.y = ey;
      end else begin
        predict_point(t, pt.x, pt.y);
      end
      curve_q.push_back(pt);
      n_evals++;
    end
  endtask

  // The order may change only once the block has gone quiet.
  task automatic set_order(input order_t v);
    s_axis_tvalid <= 1'b0;
    while (curve_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we      <= 1'b0;
    curve_order = v;
  endtask

  initial begin : drive_ready
    int burst;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        // Long hold-off: the output register fills and the input backs up.
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 16);
        m_axis_tready <= 1'b0;
        repeat (burst) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_results
    curve_pt_t want;
    coord_t    gx;
    coord_t    gy;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      gx = m_axis_tdata[0 +: COORD_BITS];
      gy = m_axis_tdata[COORD_BITS +: COORD_BITS];
      n_results++;
      if (curve_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got (%0d, %0d)", $time, gx, gy);
        n_errors++;
      end else begin
        want = curve_q.pop_front();
        if (gx !== want.x) begin
          $display("%0t: result_x expected %0d, got %0d", $time, want.x, gx);
          n_errors++;
        end
        if (gy !== want.y) begin
          $display("%0t: result_y expected %0d, got %0d", $time, want.y, gy);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    order_t fixed_ord [PHASES];
    order_t ord;
    fixed_ord = '{7, 0, 1, 4, 2, 5, 6, 3};
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) begin
      case (dir_tab[i].kind)
        ROW_ORDER: set_order(dir_tab[i].order);
        ROW_LOAD: begin
          send_item(CMD_LOAD, dir_tab[i].idx, dir_tab[i].x, dir_tab[i].y, dir_tab[i].t,
                    1'b0, 0, 0);
        end
        default: begin
          send_item(CMD_EVAL, dir_tab[i].idx, dir_tab[i].x, dir_tab[i].y, dir_tab[i].t,
                    dir_tab[i].chk, dir_tab[i].ex, dir_tab[i].ey);
        end
      endcase
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      ord = fixed_ord[ph];
      set_order(ord);
      if (ph == 0)
        hold_req = 1'b1;
      if (ph == PHASES - 1)
        idle_on = 1'b0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 1) == 0)
          send_item(CMD_LOAD, idx_t'($urandom_range(0, MAX_POINTS - 1)), rand_edge16(),
                    rand_edge16(), tfrac_t'($urandom), 1'b0, 0, 0);
        else
          send_item(CMD_EVAL, idx_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                    rand_edge16(), 1'b0, 0, 0);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (curve_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d loads and %0d evaluations, %0d results checked,", n_loads,
             n_evals, n_results);
    $display("over curve orders 0 to 7 with idle bursts and a long output hold-off.");
    if (n_errors == 0 && curve_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
